// ----- rtl/cds_pkg.sv -----
package cds_pkg;

  localparam int MAX_DECKS      = 8;
  localparam int CARDS_PER_DECK = 52;
  localparam int FACE_COUNT     = 13;
  localparam int STORE_DEPTH    = MAX_DECKS * CARDS_PER_DECK;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int SIZE_W         = $clog2(STORE_DEPTH + 1);
  localparam int CODE_W         = 6;
  localparam int FACE_W         = 4;
  localparam int SUIT_W         = 2;
  localparam int DECK_W         = 4;
  localparam int RND_W          = 32;
  localparam int DIV_BITS       = 2;
  localparam int DIV_STEPS      = RND_W / DIV_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_BUILD   = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_SWAP    = 2'd2,
    OP_DRAW    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_e;

  typedef enum logic [1:0] {
    SEL_CURSOR,
    SEL_POS,
    SEL_J
  } addr_sel_e;

  typedef struct packed {
    logic      build_init;
    logic      build_step;
    logic      shuffle_init;
    logic      div_start;
    addr_sel_e rd_sel;
    logic      cap_tmp;
    logic      wr_cursor;
    logic      wr_j;
    logic      swap_done;
    logic      draw_done;
    logic      finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic build_last;
    logic shuffling;
    logic div_last;
  } ctrl_stat_t;

endpackage

// ----- rtl/cds_divmod.sv -----
module cds_divmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cds_pkg::RND_W-1:0]  dividend_i,
  input  logic [cds_pkg::SIZE_W-1:0] divisor_i,
  output logic                       last_o,
  output logic [cds_pkg::SIZE_W-1:0] rem_o
);

  logic                          active_q;
  logic [cds_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [cds_pkg::RND_W-1:0]     dvd_q;
  logic [cds_pkg::SIZE_W-1:0]    div_q;
  logic [cds_pkg::SIZE_W-1:0]    rem_q;
  logic [cds_pkg::SIZE_W-1:0]    rem_d;

  // restoring remainder, two dividend bits per cycle
  always_comb begin
    logic [cds_pkg::SIZE_W:0]   w;
    logic [cds_pkg::SIZE_W-1:0] r;
    r = rem_q;
    for (int k = 0; k < cds_pkg::DIV_BITS; k++) begin
      w = {r, dvd_q[cds_pkg::RND_W-1-k]};
      if (w >= {1'b0, div_q}) begin
        w = w - {1'b0, div_q};
      end
      r = w[cds_pkg::SIZE_W-1:0];
    end
    rem_d = r;
  end

  assign last_o = active_q && (cnt_q == cds_pkg::DIV_CNT_W'(cds_pkg::DIV_STEPS - 1));
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else if (active_q) begin
      active_q <= !last_o;
      cnt_q    <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (active_q) begin
      dvd_q <= dvd_q << cds_pkg::DIV_BITS;
      rem_q <= rem_d;
    end
  end

endmodule

// ----- rtl/cds_ctrl.sv -----
module cds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          opcode_i,
  input  cds_pkg::ctrl_stat_t stat_i,
  output logic                busy_o,
  output cds_pkg::ctrl_cmd_t  cmd_o
);

  cds_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cds_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != cds_pkg::ST_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = cds_pkg::SEL_CURSOR;
    case (state_q)
      cds_pkg::ST_IDLE: begin
        if (start_i) begin
          case (cds_pkg::op_e'(opcode_i))
            cds_pkg::OP_BUILD: begin
              cmd_o.build_init = 1'b1;
              state_d          = cds_pkg::ST_BUILD;
            end
            cds_pkg::OP_SHUFFLE: begin
              cmd_o.shuffle_init = 1'b1;
              cmd_o.finish       = 1'b1;
            end
            cds_pkg::OP_SWAP: begin
              if (stat_i.shuffling) begin
                cmd_o.div_start = 1'b1;
                state_d         = cds_pkg::ST_DIV;
              end else begin
                cmd_o.finish = 1'b1;
              end
            end
            default: begin
              state_d = cds_pkg::ST_DRAW_RD;
            end
          endcase
        end
      end
      cds_pkg::ST_BUILD: begin
        cmd_o.build_step = 1'b1;
        if (stat_i.build_last) begin
          cmd_o.finish = 1'b1;
          state_d      = cds_pkg::ST_IDLE;
        end
      end
      cds_pkg::ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = cds_pkg::ST_RD_A;
        end
      end
      cds_pkg::ST_RD_A: begin
        cmd_o.rd_sel = cds_pkg::SEL_CURSOR;
        state_d      = cds_pkg::ST_RD_B;
      end
      cds_pkg::ST_RD_B: begin
        // cursor entry is in the read register now
        cmd_o.rd_sel  = cds_pkg::SEL_J;
        cmd_o.cap_tmp = 1'b1;
        state_d       = cds_pkg::ST_WR_A;
      end
      cds_pkg::ST_WR_A: begin
        cmd_o.wr_cursor = 1'b1;
        state_d         = cds_pkg::ST_WR_B;
      end
      cds_pkg::ST_WR_B: begin
        cmd_o.wr_j      = 1'b1;
        cmd_o.swap_done = 1'b1;
        cmd_o.finish    = 1'b1;
        state_d         = cds_pkg::ST_IDLE;
      end
      cds_pkg::ST_DRAW_RD: begin
        cmd_o.rd_sel = cds_pkg::SEL_POS;
        state_d      = cds_pkg::ST_DRAW_OUT;
      end
      cds_pkg::ST_DRAW_OUT: begin
        cmd_o.draw_done = 1'b1;
        cmd_o.finish    = 1'b1;
        state_d         = cds_pkg::ST_IDLE;
      end
      default: begin
        state_d = cds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/cds_datapath.sv -----
module cds_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cds_pkg::ctrl_cmd_t         cmd_i,
  input  logic [cds_pkg::RND_W-1:0]  random_value_i,
  input  logic                       cfg_valid_i,
  input  logic [cds_pkg::DECK_W-1:0] cfg_data_i,
  output cds_pkg::ctrl_stat_t        stat_o,
  output logic                       done_o,
  output logic [cds_pkg::FACE_W-1:0] card_face_o,
  output logic [cds_pkg::SUIT_W-1:0] card_suit_o,
  output logic                       card_valid_o,
  output logic                       reshuffle_due_o,
  output logic                       shuffle_active_o
);

  logic [cds_pkg::CODE_W-1:0] mem [cds_pkg::STORE_DEPTH];

  logic [cds_pkg::DECK_W-1:0] deck_q;
  logic [cds_pkg::SIZE_W-1:0] size_q;
  logic [cds_pkg::ADDR_W-1:0] pos_q;
  logic [cds_pkg::ADDR_W-1:0] cursor_q;
  logic                       shuffling_q;
  logic [cds_pkg::ADDR_W-1:0] baddr_q;
  logic [cds_pkg::CODE_W-1:0] code_q;
  logic [cds_pkg::CODE_W-1:0] rdata_q;
  logic [cds_pkg::CODE_W-1:0] tmp_q;
  logic                       done_q;
  logic [cds_pkg::FACE_W-1:0] face_q;
  logic [cds_pkg::SUIT_W-1:0] suit_q;
  logic                       valid_q;
  logic                       due_q;

  logic [cds_pkg::DECK_W-1:0] eff_deck;
  logic [cds_pkg::SIZE_W-1:0] eff_size;
  logic [cds_pkg::SIZE_W-1:0] rem;
  logic                       div_last;
  logic [cds_pkg::ADDR_W-1:0] j_addr;
  logic [cds_pkg::ADDR_W-1:0] raddr;
  logic [cds_pkg::ADDR_W-1:0] waddr;
  logic [cds_pkg::CODE_W-1:0] wdata;
  logic                       we;
  logic [cds_pkg::SIZE_W-1:0] pos_inc;
  logic                       wrap;

  // zero deck count reads as one deck, too many as the maximum
  always_comb begin
    eff_deck = deck_q;
    if (deck_q == '0) begin
      eff_deck = cds_pkg::DECK_W'(1);
    end else if ({1'b0, deck_q} > (cds_pkg::DECK_W + 1)'(cds_pkg::MAX_DECKS)) begin
      eff_deck = cds_pkg::DECK_W'(cds_pkg::MAX_DECKS);
    end
  end

  assign eff_size = cds_pkg::SIZE_W'(cds_pkg::SIZE_W'(eff_deck)
                    * cds_pkg::SIZE_W'(cds_pkg::CARDS_PER_DECK));

  cds_divmod u_divmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (random_value_i),
    .divisor_i  (cds_pkg::SIZE_W'(cursor_q) + 1'b1),
    .last_o     (div_last),
    .rem_o      (rem)
  );

  assign j_addr = cds_pkg::ADDR_W'(rem);

  assign stat_o.build_last = (baddr_q == cds_pkg::ADDR_W'(size_q - 1'b1));
  assign stat_o.shuffling  = shuffling_q;
  assign stat_o.div_last   = div_last;

  always_comb begin
    case (cmd_i.rd_sel)
      cds_pkg::SEL_POS: raddr = pos_q;
      cds_pkg::SEL_J:   raddr = j_addr;
      default:          raddr = cursor_q;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = baddr_q;
    wdata = code_q;
    if (cmd_i.wr_cursor) begin
      waddr = cursor_q;
      wdata = rdata_q;
    end else if (cmd_i.wr_j) begin
      waddr = j_addr;
      wdata = tmp_q;
    end else if (!cmd_i.build_step) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign pos_inc = cds_pkg::SIZE_W'(pos_q) + 1'b1;
  assign wrap    = (pos_inc >= size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deck_q      <= cds_pkg::DECK_W'(1);
      size_q      <= cds_pkg::SIZE_W'(cds_pkg::CARDS_PER_DECK);
      pos_q       <= '0;
      cursor_q    <= '0;
      shuffling_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cfg_valid_i) begin
        deck_q <= cfg_data_i;
      end
      if (cmd_i.build_init) begin
        size_q      <= eff_size;
        pos_q       <= '0;
        cursor_q    <= '0;
        shuffling_q <= 1'b0;
      end else if (cmd_i.shuffle_init) begin
        cursor_q    <= cds_pkg::ADDR_W'(size_q - 1'b1);
        shuffling_q <= (size_q > cds_pkg::SIZE_W'(1));
        pos_q       <= '0;
      end else if (cmd_i.swap_done) begin
        cursor_q    <= cursor_q - 1'b1;
        shuffling_q <= (cursor_q != cds_pkg::ADDR_W'(1));
      end else if (cmd_i.draw_done) begin
        pos_q <= wrap ? '0 : cds_pkg::ADDR_W'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      baddr_q <= '0;
      code_q  <= '0;
    end else if (cmd_i.build_step) begin
      baddr_q <= baddr_q + 1'b1;
      // code runs through face*4+suit, restarting with each deck
      code_q  <= (code_q == cds_pkg::CODE_W'(cds_pkg::CARDS_PER_DECK - 1))
                 ? '0 : code_q + 1'b1;
    end
    if (cmd_i.cap_tmp) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.finish) begin
      if (cmd_i.draw_done) begin
        face_q  <= rdata_q[cds_pkg::CODE_W-1:cds_pkg::SUIT_W];
        suit_q  <= rdata_q[cds_pkg::SUIT_W-1:0];
        valid_q <= 1'b1;
        due_q   <= wrap;
      end else begin
        face_q  <= '0;
        suit_q  <= '0;
        valid_q <= 1'b0;
        due_q   <= 1'b0;
      end
    end
  end

  assign done_o           = done_q;
  assign card_face_o      = face_q;
  assign card_suit_o      = suit_q;
  assign card_valid_o     = valid_q;
  assign reshuffle_due_o  = due_q;
  assign shuffle_active_o = shuffling_q;

endmodule

// ----- rtl/card_deck_shuffle_draw.sv -----
// Card shoe: build an ordered shoe, shuffle it step by step, draw cards.
// Command channel: opcode_i and random_value_i are taken at a clock edge
// where start_i is high and busy_o is low. busy_o stays high until the
// item is finished. Every item gives one result: done_o pulses for one
// cycle with card_face_o, card_suit_o, card_valid_o, reshuffle_due_o and
// shuffle_active_o; the receiver must take it in that cycle.
// Steps from accept to done_o:
//   start shuffle, or swap when no shuffle runs: finished at accept, result registered
//   draw: store read, then result
//   swap step: remainder in the 2-bit-per-cycle unit, then the
//     read-read-write-write swap through the store, then result
//   build: one store entry per cycle for the whole shoe, then result
// A new item may be accepted in the cycle in which done_o is shown.
// Configuration: cfg_data_i is written to the deck count whenever
// cfg_valid_i is high (cfg_ready_o is always high); write it while idle.
// The deck count takes effect at the next build.
// Reset clears the position, cursor and shuffle flag, sets the deck count
// to one and the shoe size to 52; the card store holds nothing until built.
module card_deck_shuffle_draw (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 opcode_i,
  input  logic [cds_pkg::RND_W-1:0]  random_value_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cds_pkg::DECK_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [cds_pkg::FACE_W-1:0] card_face_o,
  output logic [cds_pkg::SUIT_W-1:0] card_suit_o,
  output logic                       card_valid_o,
  output logic                       reshuffle_due_o,
  output logic                       shuffle_active_o
);

  cds_pkg::ctrl_cmd_t  cmd;
  cds_pkg::ctrl_stat_t stat;
  logic                busy;
  logic                start;

  assign start       = start_i && !busy;
  assign busy_o      = busy;
  assign cfg_ready_o = 1'b1;

  cds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  cds_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .random_value_i   (random_value_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .stat_o           (stat),
    .done_o           (done_o),
    .card_face_o      (card_face_o),
    .card_suit_o      (card_suit_o),
    .card_valid_o     (card_valid_o),
    .reshuffle_due_o  (reshuffle_due_o),
    .shuffle_active_o (shuffle_active_o)
  );

endmodule

// ----- rtl/cds_checker.sv -----
module cds_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [3:0] card_face_o,
  input logic [1:0] card_suit_o,
  input logic       card_valid_o,
  input logic       reshuffle_due_o,
  input logic       shuffle_active_o
);

  // an accepted item either finishes at once or keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted item neither busy nor done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !card_valid_o |-> card_face_o == 4'd0 && card_suit_o == 2'd0)
    else $error("card fields set without a drawn card");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && reshuffle_due_o |-> card_valid_o)
    else $error("reshuffle flag outside a draw");

  // a shuffle only starts with a finished item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(shuffle_active_o) |-> done_o)
    else $error("shuffle started without a result");

endmodule

bind card_deck_shuffle_draw cds_checker u_cds_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .card_face_o      (card_face_o),
  .card_suit_o      (card_suit_o),
  .card_valid_o     (card_valid_o),
  .reshuffle_due_o  (reshuffle_due_o),
  .shuffle_active_o (shuffle_active_o)
);
